[rtl/core/sdram_device_model_assert.svh]
// Assertion macros shared by the SDRAM device model RTL.
`ifndef SDRAM_DEVICE_MODEL_ASSERT_SVH
`define SDRAM_DEVICE_MODEL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sdm_pkg.sv]
// Shared constants and types for the SDRAM device model.
`timescale 1ns / 1ps

package sdm_pkg;

  localparam int ROW_BITS    = 13;
  localparam int COL_BITS    = 9;
  localparam int BANK_BITS   = 2;
  localparam int BANK_COUNT  = 4;
  localparam int PIN_BITS    = 13;
  localparam int DATA_BITS   = 16;
  localparam int LANE_COUNT  = 2;
  localparam int BYTE_BITS   = 8;
  localparam int ADDR_BITS   = BANK_BITS + ROW_BITS + COL_BITS;
  localparam int MEM_WORDS   = 1 << ADDR_BITS;
  localparam int OFFSET_BITS = 3;
  localparam int DELAY_BITS  = 2;

  localparam logic [OFFSET_BITS-1:0] BURST_MAX   = 3'd7;
  localparam logic [DELAY_BITS-1:0]  BURST_DELAY = 2'd2;

  // One memory access per accepted sample: a read for the result, an optional
  // byte-lane write for a WRITE command.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [LANE_COUNT-1:0] wr_lanes;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [DATA_BITS-1:0]  wr_data;
  } mem_req_t;

endpackage

[rtl/core/sdram_device_model.sv]
// Top level of the SDRAM device model: handshake, pipeline and output register.
`timescale 1ns / 1ps
`include "sdram_device_model_assert.svh"

// Device side of a 16-bit SDR SDRAM (4 banks x 8192 rows x 512 columns, 16M
// words). Each input transfer is one sample of the command pins on an SDRAM
// clock edge; each produces exactly one read_data transfer, in order. A command
// counts only if the previous sample's clock_enable was high and chip_select_n
// is low. ACTIVATE stores the row for the bank; READ/WRITE forms the word address
// {bank, open row, column}; WRITE stores the byte lanes that byte_mask leaves
// enabled; READ restarts the burst offset, which holds at 0 for two further
// samples and then counts up to 7 and stays there. read_data is the word at
// access address plus burst offset, after this sample's write.
// Rate: one sample per clock, sustained, while out_ready stays high. The word
// array is read into s1 at the input transfer edge and the output register
// loads from s1 when it is empty or its transfer is taken, so read_data passes
// through s1 and then the output register. The word array has one
// byte-lane write port and one read port, used once each per sample, which sets
// that rate; a write and read of the same word in one cycle are resolved by
// forwarding the written lanes. A stalled output back-pressures in_ready after
// two samples are in flight. The word array has no reset and no clearing pass:
// a word never written reads as whatever it holds.
module sdram_device_model import sdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  clock_enable,
  input  logic                  chip_select_n,
  input  logic                  row_strobe_n,
  input  logic                  column_strobe_n,
  input  logic                  write_enable_n,
  input  logic [BANK_BITS-1:0]  bank,
  input  logic [PIN_BITS-1:0]   address_pins,
  input  logic [LANE_COUNT-1:0] byte_mask,
  input  logic [DATA_BITS-1:0]  write_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_BITS-1:0]  read_data
);

  mem_req_t             req;
  logic                 accept;
  logic                 advance;
  logic                 s1_valid;
  logic [DATA_BITS-1:0] s1_data;

  // s1 holds the read data until the output register frees up; the array is
  // not read again meanwhile, so its registered output stays put.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  sdm_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .clock_enable    (clock_enable),
    .chip_select_n   (chip_select_n),
    .row_strobe_n    (row_strobe_n),
    .column_strobe_n (column_strobe_n),
    .write_enable_n  (write_enable_n),
    .bank            (bank),
    .address_pins    (address_pins),
    .byte_mask       (byte_mask),
    .write_data      (write_data),
    .req             (req)
  );

  sdm_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // output register: loads when s1 moves on, empties on a taken transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= s1_data;
    end
  end

  `SDM_ASSERT_NOW(a_stall_only_when_full, !in_ready,
    s1_valid && out_valid && !out_ready, "input stalled with room in the pipeline")
  `SDM_ASSERT_NEXT(a_transfer_fills_s1, accept, s1_valid, "accepted sample lost before s1")

endmodule

[rtl/core/sdm_ctrl.sv]
// Command decode, open-row table, access address and burst counters.
`timescale 1ns / 1ps
`include "sdram_device_model_assert.svh"

module sdm_ctrl import sdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  clock_enable,
  input  logic                  chip_select_n,
  input  logic                  row_strobe_n,
  input  logic                  column_strobe_n,
  input  logic                  write_enable_n,
  input  logic [BANK_BITS-1:0]  bank,
  input  logic [PIN_BITS-1:0]   address_pins,
  input  logic [LANE_COUNT-1:0] byte_mask,
  input  logic [DATA_BITS-1:0]  write_data,
  output mem_req_t              req
);

  logic [ROW_BITS-1:0]    open_rows [BANK_COUNT];
  logic [ADDR_BITS-1:0]   access_address;
  logic [OFFSET_BITS-1:0] burst_offset;
  logic [DELAY_BITS-1:0]  burst_delay;
  logic                   prior_clock_enable;

  logic                   cmd_ok, is_act, is_rw, is_wr, is_rd;
  logic [ADDR_BITS-1:0]   lin_addr;
  logic [ADDR_BITS-1:0]   access_address_next;
  logic [OFFSET_BITS-1:0] offset_used, burst_offset_next;
  logic [DELAY_BITS-1:0]  delay_used, burst_delay_next;

  always_comb begin
    cmd_ok = prior_clock_enable & ~chip_select_n;
    is_act = cmd_ok & ~row_strobe_n & column_strobe_n & write_enable_n;
    is_rw  = cmd_ok & row_strobe_n & ~column_strobe_n;
    is_wr  = is_rw & ~write_enable_n;
    is_rd  = is_rw & write_enable_n;

    lin_addr = {bank, open_rows[bank], address_pins[COL_BITS-1:0]};
    access_address_next = is_rw ? lin_addr : access_address;

    // a read restarts the burst before this sample's word is looked up
    offset_used = is_rd ? '0 : burst_offset;
    delay_used  = is_rd ? BURST_DELAY : burst_delay;

    burst_offset_next = offset_used;
    burst_delay_next  = delay_used;
    if (delay_used == '0) begin
      if (offset_used < BURST_MAX) begin
        burst_offset_next = offset_used + 1'b1;
      end
    end else begin
      burst_delay_next = delay_used - 1'b1;
    end
  end

  always_comb begin
    req.rd_en    = accept;
    req.rd_addr  = access_address_next + ADDR_BITS'(offset_used);
    req.wr_lanes = (accept && is_wr) ? ~byte_mask : '0;
    req.wr_addr  = lin_addr;
    req.wr_data  = write_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANK_COUNT; i++) begin
        open_rows[i] <= '0;
      end
      access_address     <= '0;
      burst_offset       <= '0;
      burst_delay        <= '0;
      prior_clock_enable <= 1'b0;
    end else if (accept) begin
      if (is_act) begin
        open_rows[bank] <= address_pins[ROW_BITS-1:0];
      end
      access_address     <= access_address_next;
      burst_offset       <= burst_offset_next;
      burst_delay        <= burst_delay_next;
      prior_clock_enable <= clock_enable;
    end
  end

  `SDM_ASSERT_NEXT(a_read_restarts_burst, accept && is_rd,
    burst_offset == '0 && burst_delay == BURST_DELAY - 1'b1, "read did not restart burst")
  `SDM_ASSERT_NEXT(a_idle_holds_address, !accept,
    $stable(access_address) && $stable(burst_offset), "state moved without a transfer")
  `SDM_ASSERT_NEXT(a_burst_steps, accept && delay_used == '0 && offset_used < BURST_MAX,
    burst_offset == $past(offset_used) + 1'b1, "burst offset did not advance")

endmodule

[rtl/core/sdm_mem.sv]
// Word store with byte-lane writes, registered read and same-cycle forwarding.
`timescale 1ns / 1ps

module sdm_mem import sdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  mem_req_t             req,
  input  logic                 advance,
  output logic                 s1_valid,
  output logic [DATA_BITS-1:0] s1_data
);

  logic [DATA_BITS-1:0]  mem [MEM_WORDS];
  logic [DATA_BITS-1:0]  rd_data;
  logic [LANE_COUNT-1:0] fwd_lanes;
  logic [DATA_BITS-1:0]  fwd_data;

  // the read on this edge sees the old word; written lanes come via forwarding
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANE_COUNT; l++) begin
      if (req.wr_lanes[l]) begin
        mem[req.wr_addr][l*BYTE_BITS +: BYTE_BITS] <= req.wr_data[l*BYTE_BITS +: BYTE_BITS];
      end
    end
    if (req.rd_en) begin
      rd_data   <= mem[req.rd_addr];
      fwd_lanes <= (req.rd_addr == req.wr_addr) ? req.wr_lanes : '0;
      fwd_data  <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.rd_en) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    for (int l = 0; l < LANE_COUNT; l++) begin
      s1_data[l*BYTE_BITS +: BYTE_BITS] = fwd_lanes[l] ? fwd_data[l*BYTE_BITS +: BYTE_BITS]
                                                       : rd_data[l*BYTE_BITS +: BYTE_BITS];
    end
  end

endmodule
